@@ design/nfab_pkg.sv @@
// Shared types and constants for the Thompson NFA builder.
package nfab_pkg;

    // State numbering
    localparam int STATE_BITS  = 12;
    localparam int NUM_W       = STATE_BITS + 1;
    localparam int STATE_LIMIT = 1 << STATE_BITS;

    // Queue depths between the parts
    localparam int CMD_Q_DEPTH = 2;
    localparam int REC_Q_DEPTH = 4;

    // Token codes on req_type
    localparam logic [2:0] TOK_LIT  = 3'd0;
    localparam logic [2:0] TOK_CAT  = 3'd1;
    localparam logic [2:0] TOK_ALT  = 3'd2;
    localparam logic [2:0] TOK_STAR = 3'd3;
    localparam logic [2:0] TOK_END  = 3'd4;

    // Record kinds
    localparam logic [2:0] KIND_SYM   = 3'd0;
    localparam logic [2:0] KIND_EPS   = 3'd1;
    localparam logic [2:0] KIND_INIT  = 3'd2;
    localparam logic [2:0] KIND_FINAL = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_UNDERFLOW   = 3'd0;
    localparam logic [2:0] ERR_BAD_END     = 3'd1;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd3;
    localparam logic [2:0] ERR_EXHAUSTED   = 3'd4;

    // Classified operation
    typedef enum logic [2:0] {
        OP_LIT,
        OP_CAT,
        OP_ALT,
        OP_STAR,
        OP_END,
        OP_BAD
    } op_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] symbol;
    } req_t;

    typedef struct packed {
        logic [2:0]            rec_kind;
        logic [STATE_BITS-1:0] from_state;
        logic [7:0]            edge_symbol;
        logic [STATE_BITS-1:0] to_state;
        logic [2:0]            error_code;
        logic                  last;
    } rec_t;

    typedef struct packed {
        logic [STATE_BITS-1:0] s;
        logic [STATE_BITS-1:0] e;
    } frag_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] symbol;
    } op_item_t;

endpackage

@@ design/nfab_fifo.sv @@
// Small synchronous FIFO built from registers.
module nfab_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/nfab_front.sv @@
// Front end: accepts tokens, classifies them and queues them for the engine.
module nfab_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nfab_pkg::req_t      req,
    output logic                full,
    output nfab_pkg::op_item_t  item,
    output logic                item_valid,
    input  logic                item_take
);

    localparam int ITEM_W = $bits(nfab_pkg::op_item_t);

    nfab_pkg::op_item_t cls_item;
    logic               q_empty;
    logic [ITEM_W-1:0]  q_rd_data;

    // Classify the token
    always_comb
    begin
        cls_item.symbol = req.symbol;
        unique case (req.req_type)
            nfab_pkg::TOK_LIT:  cls_item.op = nfab_pkg::OP_LIT;
            nfab_pkg::TOK_CAT:  cls_item.op = nfab_pkg::OP_CAT;
            nfab_pkg::TOK_ALT:  cls_item.op = nfab_pkg::OP_ALT;
            nfab_pkg::TOK_STAR: cls_item.op = nfab_pkg::OP_STAR;
            nfab_pkg::TOK_END:  cls_item.op = nfab_pkg::OP_END;
            default:            cls_item.op = nfab_pkg::OP_BAD;
        endcase
    end

    // Queue classified requests toward the engine
    nfab_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (nfab_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_item),
        .full    (full),
        .rd_en   (item_take),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign item       = nfab_pkg::op_item_t'(q_rd_data);
    assign item_valid = !q_empty;

endmodule

@@ design/nfab_back.sv @@
// Back end: fragment stack, state counter and transition record emitter.
module nfab_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nfab_pkg::op_item_t item,
    input  logic               item_valid,
    output logic               item_take,
    output nfab_pkg::rec_t     rec,
    output logic               rec_valid,
    input  logic               rec_full
);

    localparam int SB     = nfab_pkg::STATE_BITS;
    localparam int NW     = nfab_pkg::NUM_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // Stack store: all fragments below the top; the top sits in a register
    nfab_pkg::frag_t mem [STACK_DEPTH];
    nfab_pkg::frag_t rd_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [NW-1:0]    num_reg, num_next;
    nfab_pkg::frag_t  top_reg, top_eff, top_next;
    logic             fix_reg, fix_next;

    // Job being emitted
    logic             job_valid_reg;
    nfab_pkg::op_t    job_op_reg;
    logic             job_err_reg;
    logic [2:0]       job_code_reg;
    logic [SB-1:0]    job_s_reg, job_e_reg;
    nfab_pkg::frag_t  job_b_reg;
    logic [7:0]       job_sym_reg;
    logic [1:0]       job_idx_reg, job_last_reg;

    // Decode results
    logic             dec_err;
    logic [2:0]       dec_code;
    logic [1:0]       dec_last;
    logic             wr_en, rd_en;
    logic             states_ok;
    logic [SB-1:0]    new_s, new_e;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    logic             emit_fire, emit_done;

    // Top fragment start is patched from the read data after a concat
    always_comb
    begin
        top_eff = top_reg;
        if (fix_reg)
        begin
            top_eff.s = rd_reg.s;
        end
    end

    assign emit_fire = job_valid_reg && !rec_full;
    assign emit_done = emit_fire && (job_idx_reg == job_last_reg);
    assign item_take = item_valid && (!job_valid_reg || emit_done);

    assign states_ok = (num_reg <= NW'(nfab_pkg::STATE_LIMIT - 2));
    assign new_s     = num_reg[SB-1:0];
    assign new_e     = new_s + SB'(1);
    assign wr_addr   = ADDR_W'(count_reg - CNT_W'(1));
    assign rd_addr   = ADDR_W'(count_reg - CNT_W'(2));

    // Check the token and work out the new stack state
    always_comb
    begin
        dec_err    = 1'b0;
        dec_code   = nfab_pkg::ERR_UNDERFLOW;
        dec_last   = 2'd0;
        count_next = count_reg;
        num_next   = num_reg;
        top_next   = top_eff;
        fix_next   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        unique case (item.op)
            nfab_pkg::OP_LIT:
            begin
                if (count_reg >= CNT_W'(STACK_DEPTH))
                begin
                    dec_err  = 1'b1;
                    dec_code = nfab_pkg::ERR_OVERFLOW;
                end
                else if (!states_ok)
                begin
                    dec_err  = 1'b1;
                    dec_code = nfab_pkg::ERR_EXHAUSTED;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    num_next   = num_reg + NW'(2);
                    top_next.s = new_s;
                    top_next.e = new_e;
                    wr_en      = (count_reg != '0);
                end
            end
            nfab_pkg::OP_CAT:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    fix_next   = 1'b1;
                    rd_en      = 1'b1;
                end
            end
            nfab_pkg::OP_ALT:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    dec_err = 1'b1;
                end
                else if (!states_ok)
                begin
                    dec_err  = 1'b1;
                    dec_code = nfab_pkg::ERR_EXHAUSTED;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    num_next   = num_reg + NW'(2);
                    top_next.s = new_s;
                    top_next.e = new_e;
                    rd_en      = 1'b1;
                    dec_last   = 2'd3;
                end
            end
            nfab_pkg::OP_STAR:
            begin
                if (count_reg == '0)
                begin
                    dec_err = 1'b1;
                end
                else if (!states_ok)
                begin
                    dec_err  = 1'b1;
                    dec_code = nfab_pkg::ERR_EXHAUSTED;
                end
                else
                begin
                    num_next   = num_reg + NW'(2);
                    top_next.s = new_s;
                    top_next.e = new_e;
                    dec_last   = 2'd3;
                end
            end
            nfab_pkg::OP_END:
            begin
                if (count_reg != CNT_W'(1))
                begin
                    dec_err  = 1'b1;
                    dec_code = nfab_pkg::ERR_BAD_END;
                end
                else
                begin
                    count_next = '0;
                    num_next   = '0;
                    dec_last   = 2'd1;
                end
            end
            default:
            begin
                dec_err  = 1'b1;
                dec_code = nfab_pkg::ERR_UNSUPPORTED;
            end
        endcase
        // Drop everything on an error
        if (dec_err)
        begin
            count_next = '0;
            num_next   = '0;
            dec_last   = 2'd0;
            fix_next   = 1'b0;
            wr_en      = 1'b0;
            rd_en      = 1'b0;
        end
    end

    // Stack control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            num_reg   <= '0;
            fix_reg   <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                count_reg <= count_next;
                num_reg   <= num_next;
            end
            fix_reg <= item_take && fix_next;
        end
    end

    // Top fragment register
    always_ff @(posedge clk)
    begin
        top_reg <= item_take ? top_next : top_eff;
    end

    // Stack store: push the old top, read the second entry
    always_ff @(posedge clk)
    begin
        if (item_take && wr_en)
        begin
            mem[wr_addr] <= top_eff;
        end
        if (item_take && rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Job control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_idx_reg   <= 2'd0;
        end
        else if (item_take)
        begin
            job_valid_reg <= 1'b1;
            job_idx_reg   <= 2'd0;
        end
        else if (emit_done)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            job_idx_reg <= job_idx_reg + 1'b1;
        end
    end

    // Job payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            job_op_reg   <= item.op;
            job_err_reg  <= dec_err;
            job_code_reg <= dec_code;
            job_s_reg    <= new_s;
            job_e_reg    <= new_e;
            job_b_reg    <= top_eff;
            job_sym_reg  <= item.symbol;
            job_last_reg <= dec_last;
        end
    end

    // Build the current record
    always_comb
    begin
        rec             = '0;
        rec.last        = (job_idx_reg == job_last_reg);
        rec.rec_kind    = nfab_pkg::KIND_EPS;
        if (job_err_reg)
        begin
            rec.rec_kind   = nfab_pkg::KIND_ERR;
            rec.error_code = job_code_reg;
        end
        else
        begin
            unique case (job_op_reg)
                nfab_pkg::OP_LIT:
                begin
                    rec.rec_kind    = nfab_pkg::KIND_SYM;
                    rec.from_state  = job_s_reg;
                    rec.edge_symbol = job_sym_reg;
                    rec.to_state    = job_e_reg;
                end
                nfab_pkg::OP_CAT:
                begin
                    rec.from_state = rd_reg.e;
                    rec.to_state   = job_b_reg.s;
                end
                nfab_pkg::OP_ALT:
                begin
                    unique case (job_idx_reg)
                        2'd0:
                        begin
                            rec.from_state = job_s_reg;
                            rec.to_state   = rd_reg.s;
                        end
                        2'd1:
                        begin
                            rec.from_state = job_s_reg;
                            rec.to_state   = job_b_reg.s;
                        end
                        2'd2:
                        begin
                            rec.from_state = rd_reg.e;
                            rec.to_state   = job_e_reg;
                        end
                        default:
                        begin
                            rec.from_state = job_b_reg.e;
                            rec.to_state   = job_e_reg;
                        end
                    endcase
                end
                nfab_pkg::OP_STAR:
                begin
                    unique case (job_idx_reg)
                        2'd0:
                        begin
                            rec.from_state = job_s_reg;
                            rec.to_state   = job_b_reg.s;
                        end
                        2'd1:
                        begin
                            rec.from_state = job_s_reg;
                            rec.to_state   = job_e_reg;
                        end
                        2'd2:
                        begin
                            rec.from_state = job_b_reg.e;
                            rec.to_state   = job_b_reg.s;
                        end
                        default:
                        begin
                            rec.from_state = job_b_reg.e;
                            rec.to_state   = job_e_reg;
                        end
                    endcase
                end
                nfab_pkg::OP_END:
                begin
                    if (job_idx_reg == 2'd0)
                    begin
                        rec.rec_kind   = nfab_pkg::KIND_INIT;
                        rec.from_state = job_b_reg.s;
                    end
                    else
                    begin
                        rec.rec_kind   = nfab_pkg::KIND_FINAL;
                        rec.from_state = job_b_reg.e;
                    end
                end
                default:
                begin
                    rec.rec_kind   = nfab_pkg::KIND_ERR;
                    rec.error_code = nfab_pkg::ERR_UNSUPPORTED;
                end
            endcase
        end
    end

    assign rec_valid = emit_fire;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fragment count beyond stack depth");

    a_num_even: assert property (@(posedge clk) disable iff (!rst_n)
        (num_reg[0] == 1'b0) && (num_reg <= NW'(nfab_pkg::STATE_LIMIT)))
        else $error("state counter odd or out of range");

    a_fix_job: assert property (@(posedge clk) disable iff (!rst_n)
        fix_reg |-> (job_valid_reg && job_op_reg == nfab_pkg::OP_CAT && job_idx_reg == 2'd0))
        else $error("concat patch pending without its job");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_idx_reg <= job_last_reg))
        else $error("record index past last record");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.op == nfab_pkg::OP_END) |=> (count_reg == '0 && num_reg == '0))
        else $error("end token did not clear the builder");

endmodule

@@ design/thompson_nfa_builder.sv @@
// Thompson NFA builder top level: postfix regex tokens in, NFA transition records out.
//
// Usage:
//   Request side is a queue: drive req and push; a request is taken at a clock edge
//   with push high and full low. Result side is a queue: while empty is low the oldest
//   record is on rec; it is taken at a clock edge with pop high and empty low.
//   Each token produces one to four records; the final one of a token has last set.
// Timing:
//   The first record of a token passes the request queue, the job registers and the
//   result queue before it appears on rec. The record emitter writes one record per
//   cycle into the result queue while that queue is not full, so record count per token
//   sets the rate; the next token is taken as the last record of a token is written.
//   A concat may follow any token at once; the second stack entry is read into a register.
// Reset:
//   rst_n low empties both queues, the fragment stack and the state counter.
//   Stack contents need no clearing pass.
// Stalls:
//   If pop stays low, the result queue fills, the emitter holds, the request
//   queue fills and full rises. No record is lost or repeated.
module thompson_nfa_builder #(
    parameter int STACK_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nfab_pkg::req_t  req,
    output logic            full,
    output logic            empty,
    input  logic            pop,
    output nfab_pkg::rec_t  rec
);

    localparam int REC_W = $bits(nfab_pkg::rec_t);

    nfab_pkg::op_item_t item;
    logic               item_valid;
    logic               item_take;
    nfab_pkg::rec_t     eng_rec;
    logic               eng_rec_valid;
    logic               rec_q_full;
    logic [REC_W-1:0]   rec_q_data;

    // Accept and classify tokens
    nfab_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .req        (req),
        .full       (full),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // Run the construction
    nfab_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .rec        (eng_rec),
        .rec_valid  (eng_rec_valid),
        .rec_full   (rec_q_full)
    );

    // Hold finished records for the receiver
    nfab_fifo #(
        .WIDTH (REC_W),
        .DEPTH (nfab_pkg::REC_Q_DEPTH)
    ) u_rec_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (eng_rec_valid),
        .wr_data (eng_rec),
        .full    (rec_q_full),
        .rd_en   (pop),
        .rd_data (rec_q_data),
        .empty   (empty)
    );

    assign rec = nfab_pkg::rec_t'(rec_q_data);

endmodule

@@ verif/nfab_record_checker.sv @@
// Record checker for the Thompson NFA builder: predicts records per request and compares them.
`timescale 1ns / 100ps

module nfab_record_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nfab_pkg::req_t   req,
    input  logic             full,
    input  logic             empty,
    input  logic             pop,
    input  nfab_pkg::rec_t   rec,
    output int               mismatches,
    output int               waiting,
    output int               checked,
    output logic [4:0]       codes_seen
);
    import nfab_pkg::*;

    // Builder image: fragment stack, fill level and next free state number
    frag_t       frags [STACK_DEPTH];
    int unsigned frag_count;
    int unsigned next_num;

    // Records owed by the block, oldest first
    rec_t        pending_records [$];
    int          fail_count;
    int          record_count;
    logic [4:0]  code_mask;

    // Queue one record; last is set once the token is complete
    function automatic void emit(logic [2:0] kind, logic [STATE_BITS-1:0] src,
                                 logic [7:0] sym, logic [STATE_BITS-1:0] dst);
        rec_t r;
        r             = '0;
        r.rec_kind    = kind;
        r.from_state  = src;
        r.edge_symbol = sym;
        r.to_state    = dst;
        pending_records.push_back(r);
    endfunction

    function automatic void close_token();
        pending_records[pending_records.size() - 1].last = 1'b1;
    endfunction

    // An error gives one record and clears the builder
    function automatic void emit_error(logic [2:0] code);
        rec_t r;
        r            = '0;
        r.rec_kind   = KIND_ERR;
        r.error_code = code;
        r.last       = 1'b1;
        pending_records.push_back(r);
        code_mask[code] = 1'b1;
        frag_count = 0;
        next_num   = 0;
    endfunction

    // Hand out a start/end pair of new state numbers
    function automatic frag_t alloc_pair();
        frag_t n;
        n.s = STATE_BITS'(next_num);
        n.e = STATE_BITS'(next_num + 1);
        next_num += 2;
        return n;
    endfunction

    function automatic bit numbers_exhausted();
        return next_num > STATE_LIMIT - 2;
    endfunction

    // Apply one postfix token to the fragment stack and queue its records
    function automatic void thompson_step(req_t t);
        frag_t a;
        frag_t b;
        frag_t n;
        case (t.req_type)
            TOK_LIT:
            begin
                if (frag_count >= STACK_DEPTH)
                    emit_error(ERR_OVERFLOW);
                else if (numbers_exhausted())
                    emit_error(ERR_EXHAUSTED);
                else
                begin
                    n = alloc_pair();
                    emit(KIND_SYM, n.s, t.symbol, n.e);
                    frags[frag_count] = n;
                    frag_count++;
                    close_token();
                end
            end
            TOK_CAT:
            begin
                if (frag_count < 2)
                    emit_error(ERR_UNDERFLOW);
                else
                begin
                    b = frags[frag_count - 1];
                    a = frags[frag_count - 2];
                    emit(KIND_EPS, a.e, 8'h00, b.s);
                    frag_count--;
                    n.s = a.s;
                    n.e = b.e;
                    frags[frag_count - 1] = n;
                    close_token();
                end
            end
            TOK_ALT:
            begin
                if (frag_count < 2)
                    emit_error(ERR_UNDERFLOW);
                else if (numbers_exhausted())
                    emit_error(ERR_EXHAUSTED);
                else
                begin
                    b = frags[frag_count - 1];
                    a = frags[frag_count - 2];
                    n = alloc_pair();
                    emit(KIND_EPS, n.s, 8'h00, a.s);
                    emit(KIND_EPS, n.s, 8'h00, b.s);
                    emit(KIND_EPS, a.e, 8'h00, n.e);
                    emit(KIND_EPS, b.e, 8'h00, n.e);
                    frag_count--;
                    frags[frag_count - 1] = n;
                    close_token();
                end
            end
            TOK_STAR:
            begin
                if (frag_count < 1)
                    emit_error(ERR_UNDERFLOW);
                else if (numbers_exhausted())
                    emit_error(ERR_EXHAUSTED);
                else
                begin
                    a = frags[frag_count - 1];
                    n = alloc_pair();
                    emit(KIND_EPS, n.s, 8'h00, a.s);
                    emit(KIND_EPS, n.s, 8'h00, n.e);
                    emit(KIND_EPS, a.e, 8'h00, a.s);
                    emit(KIND_EPS, a.e, 8'h00, n.e);
                    frags[frag_count - 1] = n;
                    close_token();
                end
            end
            TOK_END:
            begin
                if (frag_count != 1)
                    emit_error(ERR_BAD_END);
                else
                begin
                    a = frags[0];
                    emit(KIND_INIT, a.s, 8'h00, '0);
                    emit(KIND_FINAL, a.e, 8'h00, '0);
                    close_token();
                    frag_count = 0;
                    next_num   = 0;
                end
            end
            default:
                emit_error(ERR_UNSUPPORTED);
        endcase
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Match one record against the oldest expectation
    function automatic void check_record(rec_t got);
        rec_t want;
        if (pending_records.size() == 0)
        begin
            $display("%0t: record with nothing expected, actual %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = pending_records.pop_front();
            record_count++;
            compare_field("rec_kind", want.rec_kind, got.rec_kind);
            compare_field("from_state", want.from_state, got.from_state);
            compare_field("edge_symbol", want.edge_symbol, got.edge_symbol);
            compare_field("to_state", want.to_state, got.to_state);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("last", want.last, got.last);
        end
    endfunction

    // Watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_records.delete();
            frag_count   = 0;
            next_num     = 0;
            fail_count   = 0;
            record_count = 0;
            code_mask    = '0;
            mismatches   <= 0;
            waiting      <= 0;
            checked      <= 0;
            codes_seen   <= '0;
        end
        else
        begin
            if (pop && !empty)
                check_record(rec);
            if (push && !full)
                thompson_step(req);
            mismatches <= fail_count;
            waiting    <= pending_records.size();
            checked    <= record_count;
            codes_seen <= code_mask;
        end
    end

endmodule

@@ verif/tb_thompson_nfa_builder.sv @@
// Testbench top for the Thompson NFA builder: token stimulus, pacing and the verdict.
`timescale 1ns / 100ps

module tb_thompson_nfa_builder;

    localparam int STACK_DEPTH      = 64;
    localparam int RANDOM_PER_PHASE = 77;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 10;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    nfab_pkg::req_t req;
    nfab_pkg::rec_t rec;

    int         mismatches;
    int         waiting;
    int         checked;
    logic [4:0] codes_seen;

    int         tx_idle;
    int         rx_idle;
    int         phase;
    bit         hold_done;
    int         shadow_depth;
    int         tokens_sent;
    int         stall_cycles;

    always #6 clk = ~clk;

    thompson_nfa_builder #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .req   (req),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .rec   (rec)
    );

    nfab_record_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_rec_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .req        (req),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .rec        (rec),
        .mismatches (mismatches),
        .waiting    (waiting),
        .checked    (checked),
        .codes_seen (codes_seen)
    );

    // Abort when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("tb_thompson_nfa_builder NOT OK");
                $finish;
            end
        end
    end

    // Drain records; hold off once for a long stretch in the last phase
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase == 3 && !hold_done)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Follow the stack depth roughly to keep random patterns well formed
    function automatic void track_depth(logic [2:0] kind);
        case (kind)
            nfab_pkg::TOK_LIT:
                shadow_depth = (shadow_depth >= STACK_DEPTH) ? 0 : shadow_depth + 1;
            nfab_pkg::TOK_CAT, nfab_pkg::TOK_ALT:
                shadow_depth = (shadow_depth < 2) ? 0 : shadow_depth - 1;
            nfab_pkg::TOK_STAR:
                if (shadow_depth < 1)
                    shadow_depth = 0;
            default:
                shadow_depth = 0;
        endcase
    endfunction

    // Offer one request after an optional gap and wait until it is taken
    task automatic send_token(logic [2:0] kind, logic [7:0] sym);
        while ($urandom_range(99) < tx_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        req.req_type <= kind;
        req.symbol   <= sym;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tokens_sent++;
        track_depth(kind);
    endtask

    // Pick a token that mostly keeps the pattern legal, with some noise
    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 3'($urandom_range(7));
        if (r < 9)
            return nfab_pkg::TOK_END;
        if (shadow_depth == 0)
            return nfab_pkg::TOK_LIT;
        if (shadow_depth == 1)
            return (r < 50) ? nfab_pkg::TOK_LIT :
                   (r < 72) ? nfab_pkg::TOK_STAR : nfab_pkg::TOK_END;
        if (shadow_depth > 12)
            return (r < 55) ? nfab_pkg::TOK_CAT : nfab_pkg::TOK_ALT;
        return (r < 40) ? nfab_pkg::TOK_LIT :
               (r < 62) ? nfab_pkg::TOK_CAT :
               (r < 85) ? nfab_pkg::TOK_ALT : nfab_pkg::TOK_STAR;
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_token(pick_kind(), 8'($urandom_range(255)));
    endtask

    // Stop offering and wait for every owed record
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    initial
    begin
        push         = 1'b0;
        req          = '0;
        phase        = 1;
        tx_idle      = 17;
        rx_idle      = 85;
        hold_done    = 1'b0;
        shadow_depth = 0;
        tokens_sent  = 0;
        stall_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every token and the underflow, bad-end and unsupported error paths
        send_token(nfab_pkg::TOK_LIT, 8'h00);
        send_token(nfab_pkg::TOK_LIT, 8'hFF);
        send_token(nfab_pkg::TOK_CAT, 8'h00);
        send_token(nfab_pkg::TOK_END, 8'h00);
        send_token(nfab_pkg::TOK_CAT, 8'h00);
        send_token(nfab_pkg::TOK_STAR, 8'h00);
        send_token(nfab_pkg::TOK_LIT, 8'hAA);
        send_token(nfab_pkg::TOK_ALT, 8'h00);
        send_token(nfab_pkg::TOK_END, 8'h00);
        send_token(3'd5, 8'h5A);
        send_token(3'd6, 8'hA5);
        send_token(3'd7, 8'hFF);
        send_token(nfab_pkg::TOK_LIT, 8'h55);
        send_token(nfab_pkg::TOK_LIT, 8'h0F);
        send_token(nfab_pkg::TOK_ALT, 8'h00);
        send_token(nfab_pkg::TOK_STAR, 8'h00);
        send_token(nfab_pkg::TOK_END, 8'h00);
        send_token(nfab_pkg::TOK_LIT, 8'hF0);
        send_token(nfab_pkg::TOK_LIT, 8'h3C);
        send_token(nfab_pkg::TOK_END, 8'h00);
        send_token(nfab_pkg::TOK_LIT, 8'h01);
        send_token(nfab_pkg::TOK_STAR, 8'hFF);
        send_token(nfab_pkg::TOK_END, 8'hFF);

        // Phase one: sender mostly busy, receiver mostly stalled
        send_random(RANDOM_PER_PHASE);
        drain();

        // Phase two: roles swapped
        tx_idle = 85;
        rx_idle = 17;
        phase   = 2;
        send_random(RANDOM_PER_PHASE);
        drain();

        // Phase three: no idling, long receiver hold-off fills the block
        tx_idle = 0;
        rx_idle = 0;
        phase   = 3;
        send_random(RANDOM_PER_PHASE);

        // Fill the fragment stack and push one more literal
        send_token(nfab_pkg::TOK_END, 8'h00);
        repeat (STACK_DEPTH + 1)
            send_token(nfab_pkg::TOK_LIT, 8'($urandom_range(255)));
        send_token(nfab_pkg::TOK_END, 8'h00);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d tokens in three pacing phases plus a stack overflow run;",
                 tokens_sent);
        $display("%0d records checked, error codes seen %b", checked, codes_seen);
        if (mismatches == 0 && waiting == 0)
            $display("tb_thompson_nfa_builder OK");
        else
        begin
            $display("%0d mismatches, %0d records never arrived", mismatches, waiting);
            $display("tb_thompson_nfa_builder NOT OK");
        end
        $finish;
    end

endmodule
